>>> rtl/core/va3_pkg.sv
// ----------------------------------------------------------------------------
// va3_pkg: shared types and constants of the 3-D vector angle block
// Beat payloads, stage records and the arctangent table of the rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package va3_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 32;
    localparam int XYW          = 35;   // rotator x/y width, signed
    localparam int ZW           = 33;   // rotator angle accumulator, signed Q2.30

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    typedef struct packed {
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] first_z;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] second_z;
    } t_in;

    typedef struct packed {
        logic [15:0] angle;
        logic        zero_length;
    } t_out;

    // square root stage record, with the cosine term and flags riding along
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] res;
        logic [31:0] x;
        logic        neg;
        logic        zero;
    } t_sq;

    // rotator stage record
    typedef struct packed {
        logic signed [XYW-1:0] x;
        logic signed [XYW-1:0] y;
        logic signed [ZW-1:0]  z;
        logic                  yzero;
        logic                  xzero;
        logic                  neg;
        logic                  zero;
    } t_cor;

    // atan(2^-i) in Q2.30
    localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
        30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
        30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
        30'd32,        30'd16,        30'd8,         30'd4,         30'd2
    };

endpackage

`default_nettype wire

>>> rtl/core/va3_lane.sv
// ----------------------------------------------------------------------------
// va3_lane: one component lane
// Registers a*a, b*b and a*b for one axis of the two vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module va3_lane (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [15:0] i_a,
    input  wire logic signed [15:0] i_b,
    output logic [31:0]             o_aa,
    output logic [31:0]             o_bb,
    output logic signed [31:0]      o_ab
);

    logic signed [31:0] a_ext;
    logic signed [31:0] b_ext;
    logic [31:0]        n_aa, r_aa;
    logic [31:0]        n_bb, r_bb;
    logic signed [31:0] n_ab, r_ab;

    always_comb begin
        a_ext = 32'(i_a);
        b_ext = 32'(i_b);
        n_aa  = 32'(a_ext * a_ext);
        n_bb  = 32'(b_ext * b_ext);
        n_ab  = 32'(a_ext * b_ext);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_aa <= n_aa;
            r_bb <= n_bb;
            r_ab <= n_ab;
        end
    end

    assign o_aa = r_aa;
    assign o_bb = r_bb;
    assign o_ab = r_ab;

endmodule

`default_nettype wire

>>> rtl/core/va3_sqrt_stage.sv
// ----------------------------------------------------------------------------
// va3_sqrt_stage: one digit of the integer square root
// Tries one result bit per stage by compare and subtract on the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module va3_sqrt_stage #(
    parameter int STEP = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire va3_pkg::t_sq i_d,
    output logic              o_valid,
    output va3_pkg::t_sq      o_d
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic [64:0]  trial;
    va3_pkg::t_sq n_d, r_d;
    logic         r_valid;

    always_comb begin
        trial = {1'b0, i_d.res} + {1'b0, BIT};
        n_d   = i_d;
        if ({1'b0, i_d.rem} >= trial) begin
            n_d.rem = i_d.rem - trial[63:0];
            n_d.res = (i_d.res >> 1) + BIT;
        end else begin
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

`default_nettype wire

>>> rtl/core/va3_cordic_stage.sv
// ----------------------------------------------------------------------------
// va3_cordic_stage: one vectoring rotation
// Rotates toward the x axis by atan(2^-STEP) and accumulates the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module va3_cordic_stage #(
    parameter int STEP = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire va3_pkg::t_cor i_d,
    output logic               o_valid,
    output va3_pkg::t_cor      o_d
);

    logic signed [va3_pkg::XYW-1:0] dx;
    logic signed [va3_pkg::XYW-1:0] dy;
    logic signed [va3_pkg::ZW-1:0]  at;
    va3_pkg::t_cor                  n_d, r_d;
    logic                           r_valid;

    always_comb begin
        dx  = i_d.y >>> STEP;
        dy  = i_d.x >>> STEP;
        at  = $signed({3'b000, va3_pkg::ATAN_Q30[STEP]});
        n_d = i_d;
        if (!i_d.y[va3_pkg::XYW-1]) begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + at;
        end else begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

`default_nettype wire

>>> rtl/core/vector_angle_3d_top.sv
// ----------------------------------------------------------------------------
// vector_angle_3d_top: angle between two 3-D integer vectors
// Throughput: one beat per cycle while the output skid is empty; the fully pipelined square root
//   (32 stages) and rotator (30 stages) each take a new beat every such cycle.
// Reset: synchronous active-low i_rst_n clears all stage valids and the skid;
//   no other state is kept between beats.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_angle_3d_top #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire va3_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output va3_pkg::t_out     o_out_data
);

    localparam int          SH      = 30 - FRAC_BITS;
    localparam logic [32:0] RND     = 33'd1 << (SH - 1);
    localparam logic [32:0] PI_RND  = ({1'b0, va3_pkg::PI_Q30} + RND) >> SH;
    localparam logic [15:0] MAX_ANG = (PI_RND > 33'd65535) ? 16'hffff : PI_RND[15:0];

    // Output skid register, filled when the consumer stalls a finished beat.
    logic          r_skid_valid;
    va3_pkg::t_out r_skid;

    // Whole pipeline advances together; it holds only while the skid is full.
    logic en;
    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    // ---------------- stage 1: per-axis product lanes ----------------
    logic        r_v1;
    logic [31:0] aa_x, aa_y, aa_z, bb_x, bb_y, bb_z;
    logic signed [31:0] ab_x, ab_y, ab_z;

    va3_lane u_lane_x (
        .i_clk(i_clk), .i_en(en), .i_a(i_in_data.first_x), .i_b(i_in_data.second_x),
        .o_aa(aa_x), .o_bb(bb_x), .o_ab(ab_x)
    );
    va3_lane u_lane_y (
        .i_clk(i_clk), .i_en(en), .i_a(i_in_data.first_y), .i_b(i_in_data.second_y),
        .o_aa(aa_y), .o_bb(bb_y), .o_ab(ab_y)
    );
    va3_lane u_lane_z (
        .i_clk(i_clk), .i_en(en), .i_a(i_in_data.first_z), .i_b(i_in_data.second_z),
        .o_aa(aa_z), .o_bb(bb_z), .o_ab(ab_z)
    );

    // ---------------- stage 2: merge lanes ----------------
    // Squared lengths top out at 3*2^30, so 32 bits hold them exactly.
    logic               r_v2;
    logic [31:0]        n_na, r_na, n_nb, r_nb, n_mag, r_mag2;
    logic signed [33:0] dot;
    logic               n_neg, r_neg2, n_zero, r_zero2;

    always_comb begin
        n_na   = 32'(34'(aa_x) + 34'(aa_y) + 34'(aa_z));
        n_nb   = 32'(34'(bb_x) + 34'(bb_y) + 34'(bb_z));
        dot    = 34'(ab_x) + 34'(ab_y) + 34'(ab_z);
        n_neg  = dot[33];
        n_mag  = n_neg ? 32'(-dot) : 32'(dot);
        n_zero = (n_na == 32'd0) || (n_nb == 32'd0);
    end

    // ---------------- stage 3: length product and cosine square ----------------
    logic        r_v3;
    logic [63:0] r_p, r_m2;
    logic [31:0] r_mag3;
    logic        r_neg3, r_zero3;

    // ---------------- stage 4: sine square and per-chunk zero counts ----------------
    logic        r_v4;
    logic [63:0] r_s4, r_p4_unused_guard;
    logic [4:0]  n_lzc [4];
    logic [4:0]  r_lzc [4];
    logic [31:0] r_mag4;
    logic        r_neg4, r_zero4;

    function automatic logic [4:0] lzc16(input logic [15:0] v);
        logic [4:0] n;
        n = 5'd16;
        for (int k = 0; k < 16; k++) begin
            if (v[k]) begin
                n = 5'(15 - k);
            end
        end
        return n;
    endfunction

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_lzc[c] = lzc16(r_p[63 - 16 * c -: 16]);
        end
    end

    // ---------------- stage 5: normalize count ----------------
    // h is the smallest count with p << 2h >= 2^62, which is half the leading zeros.
    logic        r_v5;
    logic [6:0]  lz;
    logic [5:0]  r_h;
    logic [63:0] r_s5;
    logic [31:0] r_mag5;
    logic        r_neg5, r_zero5;

    always_comb begin
        if (r_lzc[0] != 5'd16) begin
            lz = 7'(r_lzc[0]);
        end else if (r_lzc[1] != 5'd16) begin
            lz = 7'd16 + 7'(r_lzc[1]);
        end else if (r_lzc[2] != 5'd16) begin
            lz = 7'd32 + 7'(r_lzc[2]);
        end else begin
            lz = 7'd48 + 7'(r_lzc[3]);
        end
    end

    // ---------------- stage 6: scale into the square root ----------------
    logic          r_v6;
    va3_pkg::t_sq  n_sq0, r_sq0;
    logic [63:0]   mag_sh;

    always_comb begin
        mag_sh      = 64'(r_mag5) << r_h;
        n_sq0.rem   = r_s5 << {r_h, 1'b0};
        n_sq0.res   = 64'd0;
        n_sq0.x     = mag_sh[31:0];
        n_sq0.neg   = r_neg5;
        n_sq0.zero  = r_zero5;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_na    <= n_na;
            r_nb    <= n_nb;
            r_mag2  <= n_mag;
            r_neg2  <= n_neg;
            r_zero2 <= n_zero;

            r_p     <= r_na * r_nb;
            r_m2    <= r_mag2 * r_mag2;
            r_mag3  <= r_mag2;
            r_neg3  <= r_neg2;
            r_zero3 <= r_zero2;

            r_s4    <= r_p - r_m2;
            r_p4_unused_guard <= r_p;
            r_lzc   <= n_lzc;
            r_mag4  <= r_mag3;
            r_neg4  <= r_neg3;
            r_zero4 <= r_zero3;

            r_h     <= lz[6:1];
            r_s5    <= r_s4;
            r_mag5  <= r_mag4;
            r_neg5  <= r_neg4;
            r_zero5 <= r_zero4 || (r_p4_unused_guard == 64'd0);

            r_sq0   <= n_sq0;
        end
    end

    // ---------------- square root pipeline ----------------
    logic         sq_v [va3_pkg::SQRT_STEPS + 1];
    va3_pkg::t_sq sq_d [va3_pkg::SQRT_STEPS + 1];

    assign sq_v[0] = r_v6;
    assign sq_d[0] = r_sq0;

    for (genvar g = 0; g < va3_pkg::SQRT_STEPS; g++) begin : g_sqrt
        va3_sqrt_stage #(.STEP(g)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(sq_v[g]), .i_d(sq_d[g]),
            .o_valid(sq_v[g + 1]), .o_d(sq_d[g + 1])
        );
    end

    // ---------------- rotator pipeline ----------------
    logic          co_v [va3_pkg::CORDIC_STEPS + 1];
    va3_pkg::t_cor co_d [va3_pkg::CORDIC_STEPS + 1];
    va3_pkg::t_sq  sq_last;
    va3_pkg::t_cor co_in;

    always_comb begin
        sq_last     = sq_d[va3_pkg::SQRT_STEPS];
        co_in.x     = $signed(va3_pkg::XYW'(sq_last.x));
        co_in.y     = $signed(va3_pkg::XYW'(sq_last.res[31:0]));
        co_in.z     = '0;
        co_in.yzero = (sq_last.res == 64'd0);
        co_in.xzero = (sq_last.x == 32'd0);
        co_in.neg   = sq_last.neg;
        co_in.zero  = sq_last.zero;
    end
    assign co_d[0] = co_in;
    assign co_v[0] = sq_v[va3_pkg::SQRT_STEPS];

    for (genvar g = 0; g < va3_pkg::CORDIC_STEPS; g++) begin : g_cordic
        va3_cordic_stage #(.STEP(g)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(co_v[g]), .i_d(co_d[g]),
            .o_valid(co_v[g + 1]), .o_d(co_d[g + 1])
        );
    end

    // ---------------- final stage: clamp, mirror, round ----------------
    va3_pkg::t_cor co_last;
    logic [31:0]   zc, theta;
    logic [32:0]   ang;
    va3_pkg::t_out n_fin, r_fin;
    logic          r_fin_valid;

    always_comb begin
        co_last = co_d[va3_pkg::CORDIC_STEPS];
        if (co_last.yzero) begin
            zc = 32'd0;
        end else if (co_last.xzero) begin
            zc = va3_pkg::HALF_PI_Q30;
        end else if (co_last.z[va3_pkg::ZW-1]) begin
            zc = 32'd0;
        end else if (co_last.z > $signed({1'b0, va3_pkg::HALF_PI_Q30})) begin
            zc = va3_pkg::HALF_PI_Q30;
        end else begin
            zc = co_last.z[31:0];
        end
        theta = co_last.neg ? (va3_pkg::PI_Q30 - zc) : zc;
        ang   = ({1'b0, theta} + RND) >> SH;
        n_fin.zero_length = co_last.zero;
        if (co_last.zero) begin
            n_fin.angle = 16'd0;
        end else if (ang > 33'd65535) begin
            n_fin.angle = 16'hffff;
        end else begin
            n_fin.angle = ang[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin <= n_fin;
        end
    end

    // Stage valids of the top-level registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_fin_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= i_in_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_v6        <= r_v5;
            r_fin_valid <= co_v[va3_pkg::CORDIC_STEPS];
        end
    end

    // ---------------- output skid ----------------
    // Park the finished beat when the consumer stalls so the pipe can still
    // shift once; drain the skid first when the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_fin_valid && !i_out_ready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid <= r_fin;
        end
    end

    assign o_out_valid = r_skid_valid || r_fin_valid;
    assign o_out_data  = r_skid_valid ? r_skid : r_fin;

    // ---------------- checks ----------------
    a_zero_gives_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_length |-> o_out_data.angle == 16'd0)
        else $error("zero-length beat with nonzero angle");

    a_angle_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.angle <= MAX_ANG)
        else $error("angle beyond pi");

    a_accept_enters_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_v1)
        else $error("accepted beat lost at lane stage");

    a_skid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_fin_valid) && !$past(i_out_ready))
        else $error("skid filled without a stalled result");

endmodule

`default_nettype wire
